FILE: rtl/tblr_pkg.sv
// Shared types and constants for the tile background line renderer.
// Used by every module of the block but tblr_shade; no dependencies of its own.
`default_nettype none

package tblr_pkg;

    // Screen geometry
    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 144;
    localparam int NWORDS        = (SCREEN_WIDTH + 31) / 32;
    localparam int REM_W         = $clog2(SCREEN_WIDTH + 1);

    // Video memory layout
    localparam int          VMEM_AW     = 13;
    localparam logic [12:0] MAP0_BASE   = 13'h1800;
    localparam logic [12:0] MAP1_BASE   = 13'h1C00;

    // Item actions
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_TILE_MODE = 2'd0;
    localparam logic [1:0] CFG_PALETTE   = 2'd1;

    // Configuration reset values
    localparam logic       TILE_MODE_RESET = 1'b1;
    localparam logic [7:0] PALETTE_RESET   = 8'hFC;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_LO,
        ST_HI,
        ST_SHADE,
        ST_FLUSH
    } fetch_state_t;

    // One access to the video memory port
    typedef struct packed {
        logic               we;
        logic [VMEM_AW-1:0] addr;
        logic [7:0]         wdata;
    } mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/tile_background_line_renderer_unit.sv
// Render: per tile, the map byte, low plane and high plane are read through the
// one memory port, the next map read overlapped with decode; 20 or 21 tiles per
// line with busy high; words strobe as each fills. Write item: taken while idle,
// one per cycle unless busy, no result. Bad line: one error word next cycle.
// Reset clears the sequencer, selects unsigned tiles and palette 0xFC; memory is not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
// Top level of the tile background line renderer; holds the config registers.
// Depends on tblr_pkg, tblr_vram, tblr_shade and tblr_fetch.
`default_nettype none

module tile_background_line_renderer_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic         action,
    input  wire logic [12:0]  vram_addr,
    input  wire logic [7:0]   vram_data,
    input  wire logic         tile_map_sel,
    input  wire logic [7:0]   x_scroll,
    input  wire logic [7:0]   y_scroll,
    input  wire logic [7:0]   line,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [7:0]   cfg_data,
    output logic              word_valid,
    output logic [63:0]       pixel_word,
    output logic [2:0]        word_index,
    output logic              last,
    output logic              line_error
);
    import tblr_pkg::*;

    logic       tile_unsigned_reg;
    logic [7:0] palette_reg;
    mem_req_t   mem_req;
    logic [7:0] mem_rdata;

    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_unsigned_reg <= TILE_MODE_RESET;
            palette_reg       <= PALETTE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TILE_MODE: tile_unsigned_reg <= cfg_data[0];
                CFG_PALETTE:   palette_reg       <= cfg_data;
                default:       ;
            endcase
        end
    end

    tblr_vram u_vram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    tblr_fetch u_fetch (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .vram_addr     (vram_addr),
        .vram_data     (vram_data),
        .tile_map_sel  (tile_map_sel),
        .x_scroll      (x_scroll),
        .y_scroll      (y_scroll),
        .line          (line),
        .tile_unsigned (tile_unsigned_reg),
        .palette       (palette_reg),
        .mem_req       (mem_req),
        .mem_rdata     (mem_rdata),
        .word_valid    (word_valid),
        .pixel_word    (pixel_word),
        .word_index    (word_index),
        .last          (last),
        .line_error    (line_error)
    );

endmodule

`default_nettype wire

FILE: rtl/tblr_vram.sv
// Video memory: 8192 x 8 single-port RAM with registered read data.
// Depends on tblr_pkg for the request struct.
`default_nettype none

module tblr_vram (
    input  wire logic              clk,
    input  wire tblr_pkg::mem_req_t req,
    output logic [7:0]             rdata
);
    import tblr_pkg::*;

    logic [7:0] mem [0:(1 << VMEM_AW) - 1];
    logic [7:0] rdata_reg;

    // Write on request, read every cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/tblr_shade.sv
// Tile row decoder: turns two bit-plane bytes into eight palette shades.
// Depends on nothing but the palette value passed in.
`default_nettype none

module tblr_shade (
    input  wire logic [7:0]  lo,
    input  wire logic [7:0]  hi,
    input  wire logic [7:0]  palette,
    output logic [15:0]      shades
);

    // Bit 7 is the leftmost pixel; pixel p lands in shades[2p+1:2p]
    always_comb
    begin
        logic [1:0] cid;
        logic [7:0] sel;
        shades = '0;
        for (int p = 0; p < 8; p++)
        begin
            cid = {hi[7 - p], lo[7 - p]};
            sel = palette >> {cid, 1'b0};
            shades[2 * p +: 2] = sel[1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tblr_fetch.sv
// Render sequencer: passes write items to the video memory port, walks the tile map
// through it, packs shades into 64-bit words and drives the result registers.
// Depends on tblr_pkg and tblr_shade.
`default_nettype none

module tblr_fetch (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 action,
    input  wire logic [12:0]          vram_addr,
    input  wire logic [7:0]           vram_data,
    input  wire logic                 tile_map_sel,
    input  wire logic [7:0]           x_scroll,
    input  wire logic [7:0]           y_scroll,
    input  wire logic [7:0]           line,
    input  wire logic                 tile_unsigned,
    input  wire logic [7:0]           palette,
    output tblr_pkg::mem_req_t        mem_req,
    input  wire logic [7:0]           mem_rdata,
    output logic                      word_valid,
    output logic [63:0]               pixel_word,
    output logic [2:0]                word_index,
    output logic                      last,
    output logic                      line_error
);
    import tblr_pkg::*;

    fetch_state_t      state_reg, state_next;
    logic [12:0]       map_base_reg, map_base_next;
    logic [4:0]        map_row_reg, map_row_next;
    logic [2:0]        pix_row_reg, pix_row_next;
    logic [4:0]        tile_x_reg, tile_x_next;
    logic [2:0]        fine_reg, fine_next;
    logic              first_reg, first_next;
    logic [12:0]       row_addr_reg, row_addr_next;
    logic [7:0]        lo_reg, lo_next;
    logic [63:0]       acc_reg, acc_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [2:0]        widx_reg, widx_next;

    logic              out_valid_reg, out_valid_next;
    logic [63:0]       out_word_reg, out_word_next;
    logic [2:0]        out_idx_reg, out_idx_next;
    logic              out_last_reg, out_last_next;
    logic              out_err_reg, out_err_next;

    logic [15:0]       shades;
    logic              accept;

    tblr_shade u_shade (
        .lo      (lo_reg),
        .hi      (mem_rdata),
        .palette (palette),
        .shades  (shades)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Next state, memory requests and word packing
    always_comb
    begin
        logic [7:0]       map_y;
        logic [2:0]       skip;
        logic [3:0]       n_px;
        logic [3:0]       take;
        logic [15:0]      t_shift;
        logic [16:0]      t_mask;
        logic [15:0]      t_px;
        logic [79:0]      combined;
        logic [5:0]       new_cnt;
        logic             full;
        logic             px_done;

        state_next     = state_reg;
        map_base_next  = map_base_reg;
        map_row_next   = map_row_reg;
        pix_row_next   = pix_row_reg;
        tile_x_next    = tile_x_reg;
        fine_next      = fine_reg;
        first_next     = first_reg;
        row_addr_next  = row_addr_reg;
        lo_next        = lo_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        widx_next      = widx_reg;

        out_valid_next = 1'b0;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        mem_req.we     = 1'b0;
        mem_req.addr   = vram_addr;
        mem_req.wdata  = vram_data;

        map_y    = y_scroll + line;
        skip     = first_reg ? fine_reg : 3'd0;
        n_px     = 4'd8 - {1'b0, skip};
        take     = (REM_W'(n_px) > rem_reg) ? rem_reg[3:0] : n_px;
        t_shift  = shades >> {skip, 1'b0};
        t_mask   = (17'h1 << {take, 1'b0}) - 17'h1;
        t_px     = t_shift & t_mask[15:0];
        combined = {16'b0, acc_reg} | ({64'b0, t_px} << {cnt_reg, 1'b0});
        new_cnt  = {1'b0, cnt_reg} + {2'b0, take};
        full     = (new_cnt >= 6'd32);
        px_done  = ((rem_reg - REM_W'(take)) == '0);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_WRITE)
                begin
                    mem_req.we = 1'b1;
                end
                else if (accept && action == ACT_RENDER)
                begin
                    if ({1'b0, line} >= 9'(SCREEN_HEIGHT))
                    begin
                        // Out-of-range line: one error word, no pixels
                        out_valid_next = 1'b1;
                        out_word_next  = '0;
                        out_idx_next   = '0;
                        out_last_next  = 1'b1;
                        out_err_next   = 1'b1;
                    end
                    else
                    begin
                        map_base_next = tile_map_sel ? MAP1_BASE : MAP0_BASE;
                        map_row_next  = map_y[7:3];
                        pix_row_next  = map_y[2:0];
                        tile_x_next   = x_scroll[7:3];
                        fine_next     = x_scroll[2:0];
                        first_next    = 1'b1;
                        acc_next      = '0;
                        cnt_next      = '0;
                        rem_next      = REM_W'(SCREEN_WIDTH);
                        widx_next     = '0;
                        state_next    = ST_MAP;
                    end
                end
            end

            ST_MAP:
            begin
                mem_req.addr = map_base_reg | {3'b0, map_row_reg, tile_x_reg};
                state_next   = ST_LO;
            end

            ST_LO:
            begin
                // Tile index arrives; form the row address of the low plane
                row_addr_next = {~tile_unsigned & ~mem_rdata[7], mem_rdata,
                                 pix_row_reg, 1'b0};
                mem_req.addr  = row_addr_next;
                state_next    = ST_HI;
            end

            ST_HI:
            begin
                lo_next      = mem_rdata;
                mem_req.addr = row_addr_reg | 13'd1;
                state_next   = ST_SHADE;
            end

            ST_SHADE:
            begin
                // Append this tile's pixels; emit a word once 32 are held or the line is done
                first_next = 1'b0;
                rem_next   = rem_reg - REM_W'(take);
                if (full)
                begin
                    acc_next = {48'b0, combined[79:64]};
                    cnt_next = 5'(new_cnt - 6'd32);
                end
                else
                begin
                    acc_next = combined[63:0];
                    cnt_next = new_cnt[4:0];
                end
                if (full || px_done)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = combined[63:0];
                    out_idx_next   = widx_reg;
                    out_last_next  = (widx_reg == 3'(NWORDS - 1));
                    out_err_next   = 1'b0;
                    widx_next      = widx_reg + 3'd1;
                end
                tile_x_next = tile_x_reg + 5'd1;
                if (!px_done)
                begin
                    // Overlap the next map read with this decode
                    mem_req.addr = map_base_reg | {3'b0, map_row_reg, tile_x_next};
                    state_next   = ST_LO;
                end
                else if (new_cnt > 6'd32)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_FLUSH:
            begin
                out_valid_next = 1'b1;
                out_word_next  = acc_reg;
                out_idx_next   = widx_reg;
                out_last_next  = 1'b1;
                out_err_next   = 1'b0;
                widx_next      = widx_reg + 3'd1;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and result payload
    always_ff @(posedge clk)
    begin
        map_base_reg <= map_base_next;
        map_row_reg  <= map_row_next;
        pix_row_reg  <= pix_row_next;
        tile_x_reg   <= tile_x_next;
        fine_reg     <= fine_next;
        first_reg    <= first_next;
        row_addr_reg <= row_addr_next;
        lo_reg       <= lo_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        widx_reg     <= widx_next;
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign word_valid = out_valid_reg;
    assign pixel_word = out_word_reg;
    assign word_index = out_idx_reg;
    assign last       = out_last_reg;
    assign line_error = out_err_reg;

endmodule

`default_nettype wire

FILE: rtl/tblr_checker.sv
// Port-level checks for the tile background line renderer, bound to the top.
// Depends on tblr_pkg and the top level's port names.
`default_nettype none

module tblr_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         start,
    input wire logic         busy,
    input wire logic         action,
    input wire logic [7:0]   line,
    input wire logic         word_valid,
    input wire logic [63:0]  pixel_word,
    input wire logic [2:0]   word_index,
    input wire logic         last,
    input wire logic         line_error
);
    import tblr_pkg::*;

    // Error word is a single, empty, final word
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && line_error |-> last && pixel_word == 64'd0 && word_index == 3'd0)
        else $error("error word malformed");

    // Final pixel word carries the last index
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !line_error && last |-> word_index == 3'(NWORDS - 1))
        else $error("last word index wrong");

    // Out-of-range line answers in the next cycle
    a_err_next: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action == ACT_RENDER && {1'b0, line} >= 9'(SCREEN_HEIGHT)
        |=> word_valid && line_error)
        else $error("missing error word");

    // A good render keeps the block busy until its last word
    a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !last |-> busy)
        else $error("idle with words outstanding");

    // A write item never makes the block busy
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action == ACT_WRITE |=> !busy && !word_valid)
        else $error("write item caused activity");

endmodule

bind tile_background_line_renderer_unit tblr_checker u_tblr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .line       (line),
    .word_valid (word_valid),
    .pixel_word (pixel_word),
    .word_index (word_index),
    .last       (last),
    .line_error (line_error)
);

`default_nettype wire

FILE: tb/line_render_checker.sv
// Checker for the tile background line renderer: mirrors video memory and the
// config registers, predicts every pixel word of a render and compares results.
// Depends on tblr_pkg for geometry, map bases, actions and register indexes.
module line_render_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        action,
    input  logic [12:0] vram_addr,
    input  logic [7:0]  vram_data,
    input  logic        tile_map_sel,
    input  logic [7:0]  x_scroll,
    input  logic [7:0]  y_scroll,
    input  logic [7:0]  line,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        word_valid,
    input  logic [63:0] pixel_word,
    input  logic [2:0]  word_index,
    input  logic        last,
    input  logic        line_error,
    output int          pending,
    output int          fail_count
);
    import tblr_pkg::*;

    localparam logic [12:0] SIGNED_TILE_BASE = 13'h1000;

    typedef struct packed {
        logic [63:0] pixels;
        logic [2:0]  index;
        logic        last;
        logic        err;
    } line_word_t;

    logic [7:0] vram_copy [0:(1 << VMEM_AW) - 1];
    logic       tile_mode_q;
    logic [7:0] palette_q;
    line_word_t expected_words [$];

    initial fail_count = 0;

    // Work out the pixel words one render produces and queue them
    function automatic void predict_line(input logic msel, input logic [7:0] sx,
                                         input logic [7:0] sy, input logic [7:0] ln);
        logic [7:0]  map_y;
        logic [7:0]  px;
        logic [7:0]  idx;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [12:0] map_addr;
        logic [12:0] row_addr;
        logic [1:0]  cid;
        logic [63:0] shades;
        int          col;
        line_word_t  wd;
        if (ln >= SCREEN_HEIGHT)
        begin
            wd.pixels = '0;
            wd.index  = '0;
            wd.last   = 1'b1;
            wd.err    = 1'b1;
            expected_words.push_back(wd);
        end
        else
        begin
            map_y = sy + ln;
            for (int w = 0; w < NWORDS; w++)
            begin
                shades = '0;
                for (int i = 0; i < 32; i++)
                begin
                    col = w * 32 + i;
                    if (col < SCREEN_WIDTH)
                    begin
                        px = sx + 8'(col);
                        map_addr = (msel ? MAP1_BASE : MAP0_BASE)
                                   + {3'b000, map_y[7:3], px[7:3]};
                        idx = vram_copy[map_addr];
                        // Signed mode: index sign-extended, times 16, off 0x1000
                        if (tile_mode_q)
                            row_addr = {1'b0, idx, 4'h0};
                        else
                            row_addr = SIGNED_TILE_BASE + {idx[7], idx, 4'h0};
                        row_addr = row_addr + {9'b0, map_y[2:0], 1'b0};
                        lo = vram_copy[row_addr];
                        hi = vram_copy[row_addr + 13'd1];
                        cid = {hi[7 - px[2:0]], lo[7 - px[2:0]]};
                        shades[2 * i +: 2] = palette_q[2 * cid +: 2];
                    end
                end
                wd.pixels = shades;
                wd.index  = 3'(w);
                wd.last   = (w == NWORDS - 1);
                wd.err    = 1'b0;
                expected_words.push_back(wd);
            end
        end
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Check results first, then take config and new words at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        line_word_t head;
        if (!rst_n)
        begin
            tile_mode_q = TILE_MODE_RESET;
            palette_q   = PALETTE_RESET;
            expected_words.delete();
            pending <= 0;
        end
        else
        begin
            if (word_valid)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected nothing, actual %0h idx %0d",
                             $time, pixel_word, word_index);
                    fail_count++;
                end
                else
                begin
                    head = expected_words.pop_front();
                    compare_field("pixel_word", head.pixels, pixel_word);
                    compare_field("word_index", 64'(head.index), 64'(word_index));
                    compare_field("last", 64'(head.last), 64'(last));
                    compare_field("line_error", 64'(head.err), 64'(line_error));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TILE_MODE)
                    tile_mode_q = cfg_data[0];
                else if (cfg_index == CFG_PALETTE)
                    palette_q = cfg_data;
            end
            if (start && !busy)
            begin
                if (action == ACT_WRITE)
                    vram_copy[vram_addr] = vram_data;
                else
                    predict_line(tile_map_sel, x_scroll, y_scroll, line);
            end
            pending <= expected_words.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top for tile_background_line_renderer_unit: clock, reset, stimulus
// and verdict. Depends on tblr_pkg, the block and line_render_checker.
module tb;
    import tblr_pkg::*;

    localparam int          CYCLE_LIMIT    = 500000;
    localparam int          SETTLE_CYCLES  = 80;
    localparam int          PHASE_ITEMS    = 8;
    localparam logic [1:0]  CFG_SPARE_LO   = 2'd2;
    localparam logic [1:0]  CFG_SPARE_HI   = 2'd3;
    // Renders stay on one map row and two pixel rows, so that every byte
    // they read is loaded first
    localparam logic [4:0]  MAP_ROW        = 5'd19;
    localparam logic [2:0]  PIX_ROW_A      = 3'd3;
    localparam logic [2:0]  PIX_ROW_B      = 3'd4;
    localparam logic [12:0] SIGNED_BASE    = 13'h1000;
    localparam int          NUM_TILES      = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        action = ACT_WRITE;
    logic [12:0] vram_addr = '0;
    logic [7:0]  vram_data = '0;
    logic        tile_map_sel = 1'b0;
    logic [7:0]  x_scroll = '0;
    logic [7:0]  y_scroll = '0;
    logic [7:0]  line = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        word_valid;
    logic [63:0] pixel_word;
    logic [2:0]  word_index;
    logic        last;
    logic        line_error;
    int          pending;
    int          fail_count;
    int          cycle_count = 0;

    tile_background_line_renderer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .vram_addr    (vram_addr),
        .vram_data    (vram_data),
        .tile_map_sel (tile_map_sel),
        .x_scroll     (x_scroll),
        .y_scroll     (y_scroll),
        .line         (line),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .word_valid   (word_valid),
        .pixel_word   (pixel_word),
        .word_index   (word_index),
        .last         (last),
        .line_error   (line_error)
    );

    line_render_checker u_check (.*);

    always #6 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** tile_background_line_renderer_unit: FAILED **");
            $finish;
        end
    end

    // Mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(15, 4);
        else
            return $urandom_range(80, 20);
    endfunction

    // Tile indexes placed in the maps: three negative, one positive
    function automatic logic [7:0] tile_id(input int k);
        case (k)
            0:       return 8'h80;
            1:       return 8'hFF;
            2:       return 8'hA5;
            default: return 8'h5A;
        endcase
    endfunction

    function automatic logic [7:0] pick_tile();
        return tile_id($urandom_range(NUM_TILES - 1));
    endfunction

    // Address of one entry in the map row that renders use
    function automatic logic [12:0] map_entry(input logic msel, input logic [4:0] col);
        return (msel ? MAP1_BASE : MAP0_BASE) | {3'b000, MAP_ROW, col};
    endfunction

    // Address of one plane byte of a tile row, unsigned or signed addressing
    function automatic logic [12:0] tile_byte(input logic signed_mode, input logic [7:0] idx,
                                              input logic [2:0] row, input logic plane);
        logic [12:0] base;
        if (signed_mode)
            base = SIGNED_BASE + {idx[7], idx, 4'h0};
        else
            base = {1'b0, idx, 4'h0};
        return base + {9'b0, row, plane};
    endfunction

    // Present one item and hold it until taken; keep start high if no gap follows
    task automatic send_item(input logic act, input logic [12:0] addr,
                             input logic [7:0] data, input logic msel,
                             input logic [7:0] sx, input logic [7:0] sy,
                             input logic [7:0] ln, input int gap);
        start        <= 1'b1;
        action       <= act;
        vram_addr    <= addr;
        vram_data    <= data;
        tile_map_sel <= msel;
        x_scroll     <= sx;
        y_scroll     <= sy;
        line         <= ln;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Pick the vertical scroll that puts the line on the loaded map row
    task automatic render(input logic msel, input logic [7:0] sx, input logic upper_row,
                          input logic [7:0] ln);
        logic [7:0] map_y;
        map_y = {MAP_ROW, upper_row ? PIX_ROW_B : PIX_ROW_A};
        send_item(ACT_RENDER, 13'($urandom), 8'($urandom), msel, sx, map_y - ln, ln,
                  pick_gap());
    endtask

    task automatic poke(input logic [12:0] addr, input logic [7:0] data, input int gap);
        send_item(ACT_WRITE, addr, data, 1'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), gap);
    endtask

    // Rewrite a loaded byte: a map entry gets a known tile, tile data anything
    task automatic poke_random();
        if ($urandom_range(1) == 0)
            poke(map_entry(1'($urandom), 5'($urandom)), pick_tile(), pick_gap());
        else
            poke(tile_byte(1'($urandom), pick_tile(),
                           ($urandom_range(1) == 0) ? PIX_ROW_A : PIX_ROW_B,
                           1'($urandom)),
                 8'($urandom), pick_gap());
    endtask

    // Mostly good lines with random scroll; some writes and some bad lines
    task automatic send_random_item();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35)
            poke_random();
        else if (roll < 88)
            render(1'($urandom), 8'($urandom), 1'($urandom),
                   8'($urandom_range(SCREEN_HEIGHT - 1)));
        else
            render(1'($urandom), 8'($urandom), 1'($urandom),
                   8'($urandom_range(255, SCREEN_HEIGHT)));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Drain all expected words, then let the block settle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] id;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the map row that renders use, in both maps
        for (int m = 0; m < 2; m++)
            for (int c = 0; c < 32; c++)
                poke(map_entry(1'(m), 5'(c)), pick_tile(), 0);

        // Load both planes of the used pixel rows of every placed tile
        for (int k = 0; k < NUM_TILES; k++)
        begin
            id = tile_id(k);
            for (int r = 0; r < 2; r++)
                for (int pl = 0; pl < 2; pl++)
                begin
                    poke(tile_byte(1'b0, id, (r != 0) ? PIX_ROW_B : PIX_ROW_A, 1'(pl)),
                         8'($urandom), 0);
                    // Signed addressing moves only tiles with a positive index
                    if (!id[7])
                        poke(tile_byte(1'b1, id, (r != 0) ? PIX_ROW_B : PIX_ROW_A, 1'(pl)),
                             8'($urandom), 0);
                end
        end

        // Reset config: unsigned tiles, default palette
        render(1'b0, 8'd0, 1'b0, 8'd0);
        render(1'b1, 8'd255, 1'b1, 8'd143);
        render(1'b0, 8'd100, 1'b0, 8'd7);
        render(1'b0, 8'd3, 1'b0, 8'd144);
        render(1'b1, 8'd255, 1'b1, 8'd255);
        poke(map_entry(1'b0, 5'd2), 8'hFF, 0);
        render(1'b0, 8'd16, 1'b0, 8'd0);

        // Signed tiles, identity palette; spare indexes must be ignored
        wait_idle();
        write_reg(CFG_TILE_MODE, 8'hFE);
        write_reg(CFG_PALETTE, 8'hE4);
        write_reg(CFG_SPARE_LO, 8'hFF);
        write_reg(CFG_SPARE_HI, 8'h00);
        render(1'b0, 8'd0, 1'b0, 8'd0);
        render(1'b1, 8'd255, 1'b1, 8'd143);
        render(1'b0, 8'd60, 1'b1, 8'd100);
        render(1'b0, 8'd0, 1'b0, 8'd200);
        poke(tile_byte(1'b1, 8'h5A, PIX_ROW_A, 1'b0), 8'hA5, 0);
        render(1'b1, 8'd200, 1'b0, 8'd1);

        // Random phases, each under its own register setting
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            case (p)
                0:
                begin
                    write_reg(CFG_TILE_MODE, 8'h01);
                    write_reg(CFG_PALETTE, 8'h00);
                end
                1:
                begin
                    write_reg(CFG_TILE_MODE, 8'h00);
                    write_reg(CFG_PALETTE, 8'hFF);
                end
                2:
                begin
                    write_reg(CFG_TILE_MODE, 8'($urandom));
                    write_reg(CFG_PALETTE, 8'($urandom));
                end
                default:
                begin
                    write_reg(CFG_TILE_MODE, 8'h01);
                    write_reg(CFG_PALETTE, 8'h1B);
                end
            endcase
            repeat (PHASE_ITEMS) send_random_item();
        end

        wait_idle();
        if (fail_count == 0)
            $display("** tile_background_line_renderer_unit: PASSED **");
        else
            $display("** tile_background_line_renderer_unit: FAILED **");
        $finish;
    end

endmodule
